[rtl/gol_pkg.sv]
// ----------------------------------------------------------------------------
// gol_pkg: shared types and constants for the life grid
// Operation codes and the B3/S23 neighbor thresholds.
// ----------------------------------------------------------------------------
package gol_pkg;

    typedef logic [1:0] t_op;
    typedef logic [3:0] t_count;

    localparam t_op OP_WRITE = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_STEP  = 2'd2;

    localparam t_count SURVIVE_MIN = 4'd2;
    localparam t_count SURVIVE_MAX = 4'd3;
    localparam t_count BIRTH_COUNT = 4'd3;

endpackage

[rtl/gol_ram.sv]
// ----------------------------------------------------------------------------
// gol_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gol_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/gol_row_rule.sv]
// ----------------------------------------------------------------------------
// gol_row_rule: next-generation row from a three-row window
// Counts the eight neighbors of every interior column and applies B3/S23.
// Edge columns, and the whole row when it is a border row, pass unchanged.
// ----------------------------------------------------------------------------
module gol_row_rule import gol_pkg::*; #(
    parameter int GRID_DIM = 64
) (
    input  logic [GRID_DIM-1:0] i_above,
    input  logic [GRID_DIM-1:0] i_mid,
    input  logic [GRID_DIM-1:0] i_below,
    input  logic                i_border_row,
    output logic [GRID_DIM-1:0] o_row
);

    for (genvar c = 0; c < GRID_DIM; c++) begin : g_col
        if (c == 0 || c == GRID_DIM - 1) begin : g_edge
            assign o_row[c] = i_mid[c];
        end else begin : g_inner
            t_count n;
            logic   alive;
            assign n = t_count'(i_above[c-1]) + t_count'(i_above[c]) + t_count'(i_above[c+1])
                     + t_count'(i_mid[c-1])                          + t_count'(i_mid[c+1])
                     + t_count'(i_below[c-1]) + t_count'(i_below[c]) + t_count'(i_below[c+1]);
            assign alive = i_mid[c] ? (n >= SURVIVE_MIN && n <= SURVIVE_MAX)
                                    : (n == BIRTH_COUNT);
            assign o_row[c] = i_border_row ? i_mid[c] : alive;
        end
    end

endmodule

[rtl/life_cellular_automaton_grid_top.sv]
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid_top: B3/S23 life grid with cell access
// Grid held as rows in two ping-pong RAM banks; a generation step sweeps the
// current bank row by row and writes the next generation into the other bank.
//
//   channel  | dir | tdata                                   | tuser
//   s_axis   | in  | [5:0] row, [11:6] col, [12] alive_in    | [1:0] op
//   m_axis   | out | [0] alive_out                           | [1:0] op_done
//
// Read and write (row read-modify-write) go through ACCESS, then FINISH; op 3 goes straight to FINISH.
// Step: one RAM row read per cycle through SWEEP plus pipeline fill, then FINISH.
// After reset a clearing pass writes GRID_DIM rows, one per cycle, before
// the first word is accepted. One item is in flight at a time; a held result
// in the output register does not block the next accept.
// ----------------------------------------------------------------------------
module life_cellular_automaton_grid_top import gol_pkg::*; #(
    parameter int GRID_DIM = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [5:0] row, [11:6] col, [12] alive_in
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] alive_out
    output logic [1:0]  o_m_axis_tuser    // [1:0] op_done
);

    localparam int AW = $clog2(GRID_DIM);
    localparam int CW = $clog2(GRID_DIM + 2);
    localparam logic [CW-1:0] CNT_ROW_LAST  = CW'(GRID_DIM - 1);
    localparam logic [CW-1:0] CNT_ROWS      = CW'(GRID_DIM);
    localparam logic [CW-1:0] CNT_SWEEP_END = CW'(GRID_DIM + 1);
    localparam logic [CW-1:0] CNT_FIRST_WR  = CW'(2);
    localparam logic [CW-1:0] CNT_ONE       = CW'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_ACCESS = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_bank, n_bank;
    logic r_out_valid, n_out_valid;
    logic r_out_alive, n_out_alive;
    t_op  r_out_op, n_out_op;

    // latched request
    t_op        r_op;
    logic [5:0] r_row;
    logic [5:0] r_col;
    logic       r_alive;

    // sweep window: rows t-3 and t-2
    logic [GRID_DIM-1:0] r_win_a, r_win_b;

    t_op        in_op;
    logic [5:0] in_row, in_col;
    logic       in_alive, in_accept, in_inside, req_inside;

    logic                rd_en, wr_en, wr_bank, win_shift;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [GRID_DIM-1:0] wr_data, rd_data, rd_data0, rd_data1, rule_row;
    logic [AW-1:0]       col_idx;
    logic [CW-1:0]       wr_row_cnt;

    assign in_op     = i_s_axis_tuser;
    assign in_row    = i_s_axis_tdata[5:0];
    assign in_col    = i_s_axis_tdata[11:6];
    assign in_alive  = i_s_axis_tdata[12];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_inside = (32'(in_row) < GRID_DIM) && (32'(in_col) < GRID_DIM);
    assign req_inside = (32'(r_row) < GRID_DIM) && (32'(r_col) < GRID_DIM);
    assign col_idx   = AW'(r_col);
    assign wr_row_cnt = r_cnt - CNT_FIRST_WR;
    assign rd_data   = r_bank ? rd_data1 : rd_data0;
    assign win_shift = (r_state == ST_SWEEP) && (r_cnt >= CNT_ONE) && (r_cnt <= CNT_ROWS);

    gol_ram #(.WIDTH(GRID_DIM), .DEPTH(GRID_DIM)) u_bank0 (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && !wr_bank),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data0)
    );

    gol_ram #(.WIDTH(GRID_DIM), .DEPTH(GRID_DIM)) u_bank1 (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && wr_bank),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data1)
    );

    gol_row_rule #(.GRID_DIM(GRID_DIM)) u_rule (
        .i_above      (r_win_a),
        .i_mid        (r_win_b),
        .i_below      (rd_data),
        .i_border_row ((r_cnt == CNT_FIRST_WR) || (r_cnt == CNT_SWEEP_END)),
        .o_row        (rule_row)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bank      = r_bank;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_alive = r_out_alive;
        n_out_op    = r_out_op;
        rd_en       = 1'b0;
        rd_addr     = AW'(in_row);
        wr_en       = 1'b0;
        wr_bank     = r_bank;
        wr_addr     = AW'(r_row);
        wr_data     = rd_data;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[AW-1:0];
                wr_data = '0;
                n_cnt   = r_cnt + CNT_ONE;
                if (r_cnt == CNT_ROW_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_cnt = '0;
                    if (in_op == OP_WRITE || in_op == OP_READ) begin
                        rd_en   = in_inside;
                        n_state = ST_ACCESS;
                    end else if (in_op == OP_STEP) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_ACCESS: begin
                // row read-modify-write; a read just waits for the data
                if (r_op == OP_WRITE && req_inside) begin
                    wr_en            = 1'b1;
                    wr_data[col_idx] = r_alive;
                end
                n_state = ST_FINISH;
            end
            ST_SWEEP: begin
                rd_en   = (r_cnt < CNT_ROWS);
                rd_addr = r_cnt[AW-1:0];
                wr_bank = !r_bank;
                wr_addr = wr_row_cnt[AW-1:0];
                wr_data = rule_row;
                wr_en   = (r_cnt >= CNT_FIRST_WR);
                n_cnt   = r_cnt + CNT_ONE;
                if (r_cnt == CNT_SWEEP_END) begin
                    n_bank  = !r_bank;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_op    = r_op;
                    n_out_alive = (r_op == OP_READ) && req_inside && rd_data[col_idx];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_alive <= n_out_alive;
        r_out_op    <= n_out_op;
        if (in_accept) begin
            r_op    <= in_op;
            r_row   <= in_row;
            r_col   <= in_col;
            r_alive <= in_alive;
        end
        if (win_shift) begin
            r_win_a <= r_win_b;
            r_win_b <= rd_data;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_alive};
    assign o_m_axis_tuser  = r_out_op;

    // a sweep never writes the bank it is reading
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && wr_en) |-> (wr_bank != r_bank))
        else $error("sweep writes the current bank");

    // the bank flips only at the end of a sweep
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bank != $past(r_bank)) |-> ($past(r_state) == ST_SWEEP))
        else $error("bank flipped outside a sweep");

    // the sweep counter stays within the sweep length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_cnt <= CNT_SWEEP_END))
        else $error("sweep counter overran");

endmodule
